>>> src/tcws_pkg.sv
// ----------------------------------------------------------------------------
// tcws_pkg
// Shared widths, register indexes and item types of the transposed-convolution
// weight splitter.
// ----------------------------------------------------------------------------
package tcws_pkg;

   // defaults of the top-level parameters
   localparam int MAX_KERNEL_SIZE_DEF = 16;
   localparam int MAX_CHANNELS_DEF    = 256;
   localparam int MAX_STRIDE_DEF      = 8;

   // internal field widths, sized for the top of each parameter's range
   localparam int KS_W  = 6;   // kernel position or quotient, below 64
   localparam int KN_W  = 7;   // kernel size, up to 64
   localparam int CH_W  = 12;  // channel position, below 4096
   localparam int CN_W  = 13;  // channel count, up to 4096
   localparam int PH_W  = 4;   // stride phase, below 16
   localparam int SN_W  = 5;   // stride, up to 16
   localparam int IDX_W = 24;  // sub-kernel index
   localparam int WGT_W = 8;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_OUT_CHANNELS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_ROWS       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_COLS       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_CHANNELS       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_VERTICAL   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_HORIZONTAL = 3'd5;

   localparam int FIFO_DEPTH = 4;

   // clamped configuration
   typedef struct packed {
      logic [CN_W-1:0] oc_n;
      logic [KN_W-1:0] kr;
      logic [KN_W-1:0] kc;
      logic [CN_W-1:0] ic_n;
      logic [SN_W-1:0] sv;
      logic [SN_W-1:0] sh;
   } cfg_type;

   // (size - 1) split by stride: quotient and remainder per axis
   typedef struct packed {
      logic [KS_W-1:0] q_row;
      logic [PH_W-1:0] rem_row;
      logic [KS_W-1:0] q_col;
      logic [PH_W-1:0] rem_col;
   } geo_type;

   // classified weight between front and back
   typedef struct packed {
      logic [CH_W-1:0]         oc;
      logic [KS_W-1:0]         q_row;
      logic [PH_W-1:0]         ph_row;
      logic [KS_W-1:0]         q_col;
      logic [PH_W-1:0]         ph_col;
      logic [CH_W-1:0]         ic;
      logic                    last;
      logic signed [WGT_W-1:0] weight;
   } item_type;

endpackage

>>> src/tcws_if.sv
// ----------------------------------------------------------------------------
// tcws_if
// Valid/ready channels of the weight splitter: weight requests and split
// responses.
// ----------------------------------------------------------------------------
interface tcws_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] weight;

   modport source (output valid, output weight, input ready);
   modport sink   (input valid, input weight, output ready);
endinterface

interface tcws_rsp_if;
   logic              valid;
   logic              ready;
   logic [2:0]        phase_row;
   logic [2:0]        phase_col;
   logic [4:0]        sub_rows;
   logic [4:0]        sub_cols;
   logic [23:0]       sub_index;
   logic signed [7:0] weight_out;
   logic              last_weight;

   modport source (output valid, output phase_row, output phase_col, output sub_rows,
                   output sub_cols, output sub_index, output weight_out,
                   output last_weight, input ready);
   modport sink   (input valid, input phase_row, input phase_col, input sub_rows,
                   input sub_cols, input sub_index, input weight_out,
                   input last_weight, output ready);
endinterface

>>> src/transpose_conv_weight_splitter.sv
// ----------------------------------------------------------------------------
// transpose_conv_weight_splitter
// Splits a transposed-convolution kernel, streamed one weight per item, into
// its stride-phase sub-kernels with flipped flat indexes.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one signed weight per item in raw order (output channel,
//   row, column, input channel). rsp_ch returns one item per weight: phase,
//   sub-kernel size, flat index in the flipped sub-kernel, the weight and a
//   last-weight flag. Both are valid/ready channels.
//   The csr_ port writes the six geometry registers; values are clamped to
//   their legal range. Any write to a listed register restarts the kernel at
//   its first weight and starts a geometry sweep over max(rows, cols) kernel
//   positions, during which req_ch.ready stays low. Write only while no item is
//   in flight. Throughput is one item per cycle while rsp_ch is ready and no
//   geometry sweep runs. A taken request is written into the queue, then passes
//   through the address stages a, b and c, each doing a multiply-add; c is the
//   response register.
//   A four-entry queue between the classifier and the address pipeline lets
//   requests keep flowing while rsp_ch is stalled; once the queue and the
//   pipeline fill, req_ch.ready drops. Reset empties everything, sets all
//   registers to 1 and clears the position counters.
// ----------------------------------------------------------------------------
module transpose_conv_weight_splitter import tcws_pkg::*; #(
   parameter int MAX_KERNEL_SIZE = MAX_KERNEL_SIZE_DEF,
   parameter int MAX_CHANNELS    = MAX_CHANNELS_DEF,
   parameter int MAX_STRIDE      = MAX_STRIDE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tcws_req_if.sink              req_ch,
   tcws_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [8:0] oc_reg_ff, oc_reg_in;
   logic [4:0] kr_reg_ff, kr_reg_in;
   logic [4:0] kc_reg_ff, kc_reg_in;
   logic [8:0] ic_reg_ff, ic_reg_in;
   logic [3:0] sv_reg_ff, sv_reg_in;
   logic [3:0] sh_reg_ff, sh_reg_in;
   logic       restart;

   cfg_type  cfg;
   geo_type  geo;
   item_type push_item, pop_item;
   logic     push, pop, q_full, q_empty, setup_busy;

   always_comb begin
      oc_reg_in = oc_reg_ff;
      kr_reg_in = kr_reg_ff;
      kc_reg_in = kc_reg_ff;
      ic_reg_in = ic_reg_ff;
      sv_reg_in = sv_reg_ff;
      sh_reg_in = sh_reg_ff;
      restart   = 1'b0;
      if (csr_we) begin
         restart = 1'b1;
         case (csr_index)
            CSR_OUT_CHANNELS:      oc_reg_in = csr_wdata;
            CSR_KERNEL_ROWS:       kr_reg_in = csr_wdata[4:0];
            CSR_KERNEL_COLS:       kc_reg_in = csr_wdata[4:0];
            CSR_IN_CHANNELS:       ic_reg_in = csr_wdata;
            CSR_STRIDE_VERTICAL:   sv_reg_in = csr_wdata[3:0];
            CSR_STRIDE_HORIZONTAL: sh_reg_in = csr_wdata[3:0];
            default:               restart   = 1'b0;   // unknown index: keep position
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oc_reg_ff <= 9'd1;
         kr_reg_ff <= 5'd1;
         kc_reg_ff <= 5'd1;
         ic_reg_ff <= 9'd1;
         sv_reg_ff <= 4'd1;
         sh_reg_ff <= 4'd1;
      end else begin
         oc_reg_ff <= oc_reg_in;
         kr_reg_ff <= kr_reg_in;
         kc_reg_ff <= kc_reg_in;
         ic_reg_ff <= ic_reg_in;
         sv_reg_ff <= sv_reg_in;
         sh_reg_ff <= sh_reg_in;
      end
   end

   // clamp: zero reads as one, large values saturate at the maximum
   always_comb begin
      cfg.oc_n = (oc_reg_ff == '0) ? CN_W'(1) :
                 (32'(oc_reg_ff) > MAX_CHANNELS) ? CN_W'(MAX_CHANNELS) : CN_W'(oc_reg_ff);
      cfg.ic_n = (ic_reg_ff == '0) ? CN_W'(1) :
                 (32'(ic_reg_ff) > MAX_CHANNELS) ? CN_W'(MAX_CHANNELS) : CN_W'(ic_reg_ff);
      cfg.kr   = (kr_reg_ff == '0) ? KN_W'(1) :
                 (32'(kr_reg_ff) > MAX_KERNEL_SIZE) ? KN_W'(MAX_KERNEL_SIZE) : KN_W'(kr_reg_ff);
      cfg.kc   = (kc_reg_ff == '0) ? KN_W'(1) :
                 (32'(kc_reg_ff) > MAX_KERNEL_SIZE) ? KN_W'(MAX_KERNEL_SIZE) : KN_W'(kc_reg_ff);
      cfg.sv   = (sv_reg_ff == '0) ? SN_W'(1) :
                 (32'(sv_reg_ff) > MAX_STRIDE) ? SN_W'(MAX_STRIDE) : SN_W'(sv_reg_ff);
      cfg.sh   = (sh_reg_ff == '0) ? SN_W'(1) :
                 (32'(sh_reg_ff) > MAX_STRIDE) ? SN_W'(MAX_STRIDE) : SN_W'(sh_reg_ff);
   end

   tcws_front u_front (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .cfg       (cfg),
      .req_ch    (req_ch),
      .fifo_full (q_full),
      .fifo_wr   (push),
      .fifo_item (push_item),
      .geo       (geo),
      .busy      (setup_busy)
   );

   tcws_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr      (push),
      .wr_item (push_item),
      .rd      (pop),
      .rd_item (pop_item),
      .full    (q_full),
      .empty   (q_empty)
   );

   tcws_back u_back (
      .clock      (clock),
      .reset      (reset),
      .geo        (geo),
      .ic_n       (cfg.ic_n),
      .fifo_empty (q_empty),
      .fifo_item  (pop_item),
      .fifo_rd    (pop),
      .rsp_ch     (rsp_ch)
   );

`ifndef NO_ASSERTIONS
   // a register write blocks requests while the geometry is re-derived
   assert property (@(posedge clock) disable iff (reset)
      (csr_we && restart) |=> (setup_busy && !req_ch.ready))
      else $error("request taken during geometry sweep");

   // reset leaves no response behind
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("response valid straight after reset");

   // the classifier never pushes into a full queue
   assert property (@(posedge clock) disable iff (reset)
      !(push && q_full && !pop))
      else $error("queue overrun");
`endif

endmodule

>>> src/tcws_front.sv
// ----------------------------------------------------------------------------
// tcws_front
// Accepts weights, tracks kernel position with phase and quotient counters,
// and classifies each weight into the queue. After a register write it sweeps
// the kernel size once to find the sub-kernel geometry.
// ----------------------------------------------------------------------------
module tcws_front import tcws_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           restart,
   input  cfg_type        cfg,
   tcws_req_if.sink       req_ch,
   input  logic           fifo_full,
   output logic           fifo_wr,
   output item_type       fifo_item,
   output geo_type        geo,
   output logic           busy
);

   logic [CH_W-1:0] oc_ff, oc_in;
   logic [KS_W-1:0] row_ff, row_in, col_ff, col_in;
   logic [CH_W-1:0] ic_ff, ic_in;
   logic [PH_W-1:0] phr_ff, phr_in, phc_ff, phc_in;
   logic [KS_W-1:0] qr_ff, qr_in, qc_ff, qc_in;

   logic            busy_ff, busy_in;
   logic [KS_W-1:0] sw_j_ff, sw_j_in;
   logic [PH_W-1:0] sw_phr_ff, sw_phr_in, sw_phc_ff, sw_phc_in;
   logic [KS_W-1:0] sw_qr_ff, sw_qr_in, sw_qc_ff, sw_qc_in;
   geo_type         geo_ff, geo_in;

   logic            accept;
   logic            ic_last, col_last, row_last, oc_last;
   logic            phr_wrap, phc_wrap, swr_wrap, swc_wrap;
   logic [KN_W-1:0] kmax;

   assign req_ch.ready = !busy_ff && !fifo_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign geo          = geo_ff;
   assign busy         = busy_ff;

   assign ic_last  = ({1'b0, ic_ff}  == cfg.ic_n - CN_W'(1));
   assign col_last = ({1'b0, col_ff} == cfg.kc - KN_W'(1));
   assign row_last = ({1'b0, row_ff} == cfg.kr - KN_W'(1));
   assign oc_last  = ({1'b0, oc_ff}  == cfg.oc_n - CN_W'(1));
   assign phr_wrap = ({1'b0, phr_ff} == cfg.sv - SN_W'(1));
   assign phc_wrap = ({1'b0, phc_ff} == cfg.sh - SN_W'(1));
   assign swr_wrap = ({1'b0, sw_phr_ff} == cfg.sv - SN_W'(1));
   assign swc_wrap = ({1'b0, sw_phc_ff} == cfg.sh - SN_W'(1));
   assign kmax     = (cfg.kr > cfg.kc) ? cfg.kr : cfg.kc;

   always_comb begin
      fifo_wr          = accept;
      fifo_item.oc     = oc_ff;
      fifo_item.q_row  = qr_ff;
      fifo_item.ph_row = phr_ff;
      fifo_item.q_col  = qc_ff;
      fifo_item.ph_col = phc_ff;
      fifo_item.ic     = ic_ff;
      fifo_item.last   = oc_last && row_last && col_last && ic_last;
      fifo_item.weight = req_ch.weight;

      oc_in  = oc_ff;
      row_in = row_ff;
      col_in = col_ff;
      ic_in  = ic_ff;
      phr_in = phr_ff;
      phc_in = phc_ff;
      qr_in  = qr_ff;
      qc_in  = qc_ff;

      // advance in raw order: input channel fastest, then column, row, output channel
      if (accept) begin
         ic_in = ic_ff + CH_W'(1);
         if (ic_last) begin
            ic_in  = '0;
            col_in = col_ff + KS_W'(1);
            phc_in = phc_ff + PH_W'(1);
            if (phc_wrap) begin
               phc_in = '0;
               qc_in  = qc_ff + KS_W'(1);
            end
            if (col_last) begin
               col_in = '0;
               phc_in = '0;
               qc_in  = '0;
               row_in = row_ff + KS_W'(1);
               phr_in = phr_ff + PH_W'(1);
               if (phr_wrap) begin
                  phr_in = '0;
                  qr_in  = qr_ff + KS_W'(1);
               end
               if (row_last) begin
                  row_in = '0;
                  phr_in = '0;
                  qr_in  = '0;
                  oc_in  = oc_last ? '0 : oc_ff + CH_W'(1);
               end
            end
         end
      end

      busy_in   = busy_ff;
      sw_j_in   = sw_j_ff;
      sw_phr_in = sw_phr_ff;
      sw_phc_in = sw_phc_ff;
      sw_qr_in  = sw_qr_ff;
      sw_qc_in  = sw_qc_ff;
      geo_in    = geo_ff;

      // geometry sweep: walk positions 0 .. max(kr, kc) - 1, latch at the last tap
      if (busy_ff) begin
         if ({1'b0, sw_j_ff} == cfg.kr - KN_W'(1)) begin
            geo_in.q_row   = sw_qr_ff;
            geo_in.rem_row = sw_phr_ff;
         end
         if ({1'b0, sw_j_ff} == cfg.kc - KN_W'(1)) begin
            geo_in.q_col   = sw_qc_ff;
            geo_in.rem_col = sw_phc_ff;
         end
         if ({1'b0, sw_j_ff} == kmax - KN_W'(1)) begin
            busy_in = 1'b0;
         end
         sw_j_in   = sw_j_ff + KS_W'(1);
         sw_phr_in = swr_wrap ? '0 : sw_phr_ff + PH_W'(1);
         sw_qr_in  = swr_wrap ? sw_qr_ff + KS_W'(1) : sw_qr_ff;
         sw_phc_in = swc_wrap ? '0 : sw_phc_ff + PH_W'(1);
         sw_qc_in  = swc_wrap ? sw_qc_ff + KS_W'(1) : sw_qc_ff;
      end

      if (restart) begin
         oc_in     = '0;
         row_in    = '0;
         col_in    = '0;
         ic_in     = '0;
         phr_in    = '0;
         phc_in    = '0;
         qr_in     = '0;
         qc_in     = '0;
         busy_in   = 1'b1;
         sw_j_in   = '0;
         sw_phr_in = '0;
         sw_phc_in = '0;
         sw_qr_in  = '0;
         sw_qc_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oc_ff     <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         ic_ff     <= '0;
         phr_ff    <= '0;
         phc_ff    <= '0;
         qr_ff     <= '0;
         qc_ff     <= '0;
         busy_ff   <= 1'b0;
         sw_j_ff   <= '0;
         sw_phr_ff <= '0;
         sw_phc_ff <= '0;
         sw_qr_ff  <= '0;
         sw_qc_ff  <= '0;
         geo_ff    <= '0;   // geometry of a 1x1 kernel at stride 1
      end else begin
         oc_ff     <= oc_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         ic_ff     <= ic_in;
         phr_ff    <= phr_in;
         phc_ff    <= phc_in;
         qr_ff     <= qr_in;
         qc_ff     <= qc_in;
         busy_ff   <= busy_in;
         sw_j_ff   <= sw_j_in;
         sw_phr_ff <= sw_phr_in;
         sw_phc_ff <= sw_phc_in;
         sw_qr_ff  <= sw_qr_in;
         sw_qc_ff  <= sw_qc_in;
         geo_ff    <= geo_in;
      end
   end

endmodule

>>> src/tcws_fifo.sv
// ----------------------------------------------------------------------------
// tcws_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module tcws_fifo import tcws_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr,
   input  item_type wr_item,
   input  logic     rd,
   output item_type rd_item,
   output logic     full,
   output logic     empty
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   item_type         mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full    = (cnt_ff == CNT_W'(FIFO_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_item = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (wr) begin
         wp_in = (wp_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_ff + PTR_W'(1);
      end
      if (rd) begin
         rp_in = (rp_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_ff + PTR_W'(1);
      end
      if (wr && !rd) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (rd && !wr) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wp_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> src/tcws_back.sv
// ----------------------------------------------------------------------------
// tcws_back
// Three-stage address pipeline: the first stage finds sub-kernel size and
// flipped tap, and each stage does one multiply-add for the flat index. The
// last stage is the response register.
// ----------------------------------------------------------------------------
module tcws_back import tcws_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  geo_type         geo,
   input  logic [CN_W-1:0] ic_n,
   input  logic            fifo_empty,
   input  item_type        fifo_item,
   output logic            fifo_rd,
   tcws_rsp_if.source      rsp_ch
);

   typedef struct packed {
      logic [IDX_W-1:0]        acc;
      logic [KN_W-1:0]         srows;
      logic [KN_W-1:0]         scols;
      logic [KS_W-1:0]         fc;
      logic [CH_W-1:0]         ic;
      logic [PH_W-1:0]         ph_row;
      logic [PH_W-1:0]         ph_col;
      logic                    last;
      logic signed [WGT_W-1:0] weight;
   } stage_type;

   logic      a_v_ff, a_v_in, b_v_ff, b_v_in, c_v_ff, c_v_in;
   stage_type a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic      a_go, b_go, c_go;
   logic [KN_W-1:0] srows, scols;
   logic [KS_W-1:0] fr, fc;

   // a stage moves when the one after it is empty or moving too
   assign c_go    = !c_v_ff || rsp_ch.ready;
   assign b_go    = !b_v_ff || c_go;
   assign a_go    = !a_v_ff || b_go;
   assign fifo_rd = !fifo_empty && a_go;

   always_comb begin
      // phases up to the remainder of (size - 1) get one extra tap
      srows = (fifo_item.ph_row <= geo.rem_row) ? {1'b0, geo.q_row} + KN_W'(1)
                                                : {1'b0, geo.q_row};
      scols = (fifo_item.ph_col <= geo.rem_col) ? {1'b0, geo.q_col} + KN_W'(1)
                                                : {1'b0, geo.q_col};
      fr    = KS_W'(srows - KN_W'(1) - {1'b0, fifo_item.q_row});
      fc    = KS_W'(scols - KN_W'(1) - {1'b0, fifo_item.q_col});

      a_in.acc    = IDX_W'(fifo_item.oc) * IDX_W'(srows) + IDX_W'(fr);
      a_in.srows  = srows;
      a_in.scols  = scols;
      a_in.fc     = fc;
      a_in.ic     = fifo_item.ic;
      a_in.ph_row = fifo_item.ph_row;
      a_in.ph_col = fifo_item.ph_col;
      a_in.last   = fifo_item.last;
      a_in.weight = fifo_item.weight;

      b_in     = a_ff;
      b_in.acc = a_ff.acc * IDX_W'(a_ff.scols) + IDX_W'(a_ff.fc);

      c_in     = b_ff;
      c_in.acc = b_ff.acc * IDX_W'(ic_n) + IDX_W'(b_ff.ic);

      a_v_in = a_go ? fifo_rd : a_v_ff;
      b_v_in = b_go ? a_v_ff : b_v_ff;
      c_v_in = c_go ? b_v_ff : c_v_ff;
   end

   always_ff @(posedge clock) begin
      if (fifo_rd) begin
         a_ff <= a_in;
      end
      if (b_go && a_v_ff) begin
         b_ff <= b_in;
      end
      if (c_go && b_v_ff) begin
         c_ff <= c_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else begin
         a_v_ff <= a_v_in;
         b_v_ff <= b_v_in;
         c_v_ff <= c_v_in;
      end
   end

   assign rsp_ch.valid       = c_v_ff;
   assign rsp_ch.phase_row   = c_ff.ph_row[2:0];
   assign rsp_ch.phase_col   = c_ff.ph_col[2:0];
   assign rsp_ch.sub_rows    = c_ff.srows[4:0];
   assign rsp_ch.sub_cols    = c_ff.scols[4:0];
   assign rsp_ch.sub_index   = c_ff.acc;
   assign rsp_ch.weight_out  = c_ff.weight;
   assign rsp_ch.last_weight = c_ff.last;

endmodule

>>> dv/tb_transpose_conv_weight_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_transpose_conv_weight_splitter
// Streams kernel weights through the splitter under many geometries, including
// clamped register values, and checks every response field against a
// behavioural predictor of phase, sub-kernel size, flipped index and last flag.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [2:0]        phase_row;
   logic [2:0]        phase_col;
   logic [4:0]        sub_rows;
   logic [4:0]        sub_cols;
   logic [23:0]       sub_index;
   logic signed [7:0] weight_out;
   logic              last_weight;
} split_type;

class split_predictor;
   int unsigned out_channels, kernel_rows, kernel_cols, in_channels;
   int unsigned stride_v, stride_h;
   int unsigned oc_pos, row_pos, col_pos, ic_pos;
   split_type   expected_splits[$];
   int unsigned mismatches;
   int unsigned checked;

   function new();
      out_channels = 1;
      kernel_rows  = 1;
      kernel_cols  = 1;
      in_channels  = 1;
      stride_v     = 1;
      stride_h     = 1;
      oc_pos       = 0;
      row_pos      = 0;
      col_pos      = 0;
      ic_pos       = 0;
      mismatches   = 0;
      checked      = 0;
   endfunction

   function void write_reg(logic [tcws_pkg::CSR_IDX_W-1:0] index,
                           logic [tcws_pkg::CSR_DATA_W-1:0] value);
      case (index)
         tcws_pkg::CSR_OUT_CHANNELS:      out_channels = 32'(value);
         tcws_pkg::CSR_KERNEL_ROWS:       kernel_rows  = 32'(value[4:0]);
         tcws_pkg::CSR_KERNEL_COLS:       kernel_cols  = 32'(value[4:0]);
         tcws_pkg::CSR_IN_CHANNELS:       in_channels  = 32'(value);
         tcws_pkg::CSR_STRIDE_VERTICAL:   stride_v     = 32'(value[3:0]);
         tcws_pkg::CSR_STRIDE_HORIZONTAL: stride_h     = 32'(value[3:0]);
         default: return;
      endcase
      // a listed write restarts the kernel
      oc_pos  = 0;
      row_pos = 0;
      col_pos = 0;
      ic_pos  = 0;
   endfunction

   static function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function int unsigned kernel_weights();
      return clamp(out_channels, tcws_pkg::MAX_CHANNELS_DEF)
           * clamp(kernel_rows, tcws_pkg::MAX_KERNEL_SIZE_DEF)
           * clamp(kernel_cols, tcws_pkg::MAX_KERNEL_SIZE_DEF)
           * clamp(in_channels, tcws_pkg::MAX_CHANNELS_DEF);
   endfunction

   function int unsigned pending();
      return expected_splits.size();
   endfunction

   function void note_weight(logic signed [7:0] w);
      int unsigned oc_n, kr, kc, ic_n, sv, sh;
      int unsigned ph_r, ph_c, srows, scols, flip_r, flip_c, idx;
      split_type   e;
      oc_n   = clamp(out_channels, tcws_pkg::MAX_CHANNELS_DEF);
      kr     = clamp(kernel_rows, tcws_pkg::MAX_KERNEL_SIZE_DEF);
      kc     = clamp(kernel_cols, tcws_pkg::MAX_KERNEL_SIZE_DEF);
      ic_n   = clamp(in_channels, tcws_pkg::MAX_CHANNELS_DEF);
      sv     = clamp(stride_v, tcws_pkg::MAX_STRIDE_DEF);
      sh     = clamp(stride_h, tcws_pkg::MAX_STRIDE_DEF);
      ph_r   = row_pos % sv;
      ph_c   = col_pos % sh;
      srows  = (kr + sv - 1 - ph_r) / sv;
      scols  = (kc + sh - 1 - ph_c) / sh;
      flip_r = srows - 1 - row_pos / sv;
      flip_c = scols - 1 - col_pos / sh;
      idx    = ((oc_pos * srows + flip_r) * scols + flip_c) * ic_n + ic_pos;
      e.phase_row   = ph_r[2:0];
      e.phase_col   = ph_c[2:0];
      e.sub_rows    = srows[4:0];
      e.sub_cols    = scols[4:0];
      e.sub_index   = idx[23:0];
      e.weight_out  = w;
      e.last_weight = (oc_pos == oc_n - 1) && (row_pos == kr - 1) &&
                      (col_pos == kc - 1) && (ic_pos == ic_n - 1);
      expected_splits = {expected_splits, e};
      // advance in raw order, input channel fastest
      ic_pos++;
      if (ic_pos >= ic_n) begin
         ic_pos = 0;
         col_pos++;
         if (col_pos >= kc) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= kr) begin
               row_pos = 0;
               oc_pos++;
               if (oc_pos >= oc_n) oc_pos = 0;
            end
         end
      end
   endfunction

   task report(string msg);
      mismatches++;
      $display("[%0t] %s", $time, msg);
   endtask

   task compare_field(string name, logic [31:0] got, logic [31:0] exp);
      if (got !== exp)
         report($sformatf("split %0d: %s = 0x%0h, expected 0x%0h", checked, name, got, exp));
   endtask

   task check_split(split_type got);
      split_type exp;
      if (expected_splits.size() == 0) begin
         report($sformatf("split %0d arrived with no weight outstanding", checked));
         return;
      end
      exp = expected_splits.pop_front();
      compare_field("phase_row", 32'(got.phase_row), 32'(exp.phase_row));
      compare_field("phase_col", 32'(got.phase_col), 32'(exp.phase_col));
      compare_field("sub_rows", 32'(got.sub_rows), 32'(exp.sub_rows));
      compare_field("sub_cols", 32'(got.sub_cols), 32'(exp.sub_cols));
      compare_field("sub_index", 32'(got.sub_index), 32'(exp.sub_index));
      compare_field("weight_out", {24'd0, got.weight_out}, {24'd0, exp.weight_out});
      compare_field("last_weight", 32'(got.last_weight), 32'(exp.last_weight));
      checked++;
   endtask
endclass

module tb_transpose_conv_weight_splitter import tcws_pkg::*;;

   localparam int IDLE_LIMIT   = 2000;
   localparam int ITEM_TARGET  = 900;
   localparam int DRAIN_CYCLES = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum int unsigned {RX_FLOW, RX_COIN, RX_LONG_STALL, RX_SPARSE} rx_mode_type;
   typedef enum int unsigned {GEO_LARGE_KERNEL, GEO_WIDE_IN, GEO_WIDE_OUT,
                              GEO_RAW, GEO_SMALL} geo_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tcws_req_if req_ch();
   tcws_rsp_if rsp_ch();

   split_predictor splits;
   int unsigned    weights_sent = 0;
   int unsigned    idle_cycles  = 0;
   int unsigned    burst_left   = 0;

   transpose_conv_weight_splitter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) splits.note_weight(req_ch.weight);
         if (rsp_ch.valid && rsp_ch.ready)
            splits.check_split(split_type'{rsp_ch.phase_row, rsp_ch.phase_col,
                                           rsp_ch.sub_rows, rsp_ch.sub_cols,
                                           rsp_ch.sub_index, rsp_ch.weight_out,
                                           rsp_ch.last_weight});
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_we)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] nothing moved for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_transpose_conv_weight_splitter NOT OK");
            $finish;
         end
      end
   end

   // receiver back-pressure, switching mode now and then
   initial begin : receiver
      rx_mode_type mode;
      int unsigned hold;
      mode = RX_FLOW;
      hold = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 63) == 0) mode = rx_mode_type'($urandom_range(0, 3));
         case (mode)
            RX_FLOW: rsp_ch.ready <= 1'b1;
            RX_COIN: rsp_ch.ready <= 1'($urandom_range(0, 1));
            RX_LONG_STALL: begin
               if (hold > 0) begin
                  hold--;
                  rsp_ch.ready <= 1'b0;
               end else begin
                  rsp_ch.ready <= 1'b1;
                  if ($urandom_range(0, 9) == 0) hold = $urandom_range(1, 20);
               end
            end
            default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   function automatic logic [7:0] random_weight();
      case ($urandom_range(0, 15))
         0:       return 8'h80;
         1:       return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   // hold the item until it is taken, then return at the next falling edge
   task automatic push_weight(input logic [7:0] w);
      req_ch.valid  <= 1'b1;
      req_ch.weight <= w;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      weights_sent++;
      @(negedge clock);
   endtask

   task automatic send_weights(input int unsigned count);
      repeat (count) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 1) == 1) begin
               req_ch.valid <= 1'b0;
               repeat ($urandom_range(1, 24)) @(negedge clock);
            end
         end
         burst_left--;
         push_weight(random_weight());
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input int unsigned value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[CSR_DATA_W-1:0];
      splits.write_reg(index, value[CSR_DATA_W-1:0]);
      @(negedge clock);
   endtask

   // drop valid and wait for every outstanding split
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (splits.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_geometry(input int unsigned oc, input int unsigned kr,
                               input int unsigned kc, input int unsigned ic,
                               input int unsigned sv, input int unsigned sh);
      int unsigned          values[6];
      int unsigned          first;
      logic [CSR_IDX_W-1:0] reg_index;
      values[CSR_OUT_CHANNELS]      = oc;
      values[CSR_KERNEL_ROWS]       = kr;
      values[CSR_KERNEL_COLS]       = kc;
      values[CSR_IN_CHANNELS]       = ic;
      values[CSR_STRIDE_VERTICAL]   = sv;
      values[CSR_STRIDE_HORIZONTAL] = sh;
      first = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) write_csr(CSR_SPARE_LO, $urandom);
      for (int k = 0; k < 6; k++) begin
         reg_index = CSR_IDX_W'((first + k) % 6);
         write_csr(reg_index, values[reg_index]);
      end
      if ($urandom_range(0, 3) == 0) write_csr(CSR_SPARE_HI, $urandom);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      geo_mode_type mode;
      int unsigned  phase, count, total;
      splits        = new();
      req_ch.valid  = 1'b0;
      req_ch.weight = '0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // reset geometry: every weight is a whole 1x1 kernel
      push_weight(8'h80);
      push_weight(8'h7F);
      push_weight(8'h00);
      push_weight(8'hFF);
      settle();

      // horizontal stride wider than the kernel, two output channels
      set_geometry(2, 3, 2, 1, 2, 4);
      send_weights(12);
      settle();

      // zero and oversized register values, clamped by the block
      set_geometry(511, 0, 31, 0, 15, 0);
      send_weights(3);
      settle();

      // unlisted index keeps the position, a listed write restarts the kernel
      write_csr(CSR_SPARE_LO, 9'h1FF);
      csr_we <= 1'b0;
      send_weights(2);
      settle();
      write_csr(CSR_SPARE_HI, 0);
      write_csr(CSR_IN_CHANNELS, 0);
      csr_we <= 1'b0;
      send_weights(2);

      phase = 0;
      while (weights_sent < ITEM_TARGET) begin
         settle();
         mode  = (phase < 4) ? geo_mode_type'(phase)
                             : (($urandom_range(0, 5) == 0) ? GEO_RAW : GEO_SMALL);
         count = 0;
         case (mode)
            GEO_LARGE_KERNEL: begin
               set_geometry(1, 16, 16, 1, $urandom_range(1, 8), $urandom_range(1, 8));
               count = 96;
            end
            GEO_WIDE_IN: begin
               set_geometry(1, 1, 1, 256, $urandom_range(1, 8), $urandom_range(1, 8));
               count = 257;
            end
            GEO_WIDE_OUT: begin
               set_geometry(256, 1, 1, 1, 1, 1);
               count = 257;
            end
            GEO_RAW: begin
               set_geometry($urandom_range(0, 511), $urandom_range(0, 31),
                            $urandom_range(0, 31), $urandom_range(0, 511),
                            $urandom_range(0, 15), $urandom_range(0, 15));
               count = $urandom_range(20, 100);
            end
            default: begin
               set_geometry($urandom_range(1, 3), $urandom_range(1, 6),
                            $urandom_range(1, 6), $urandom_range(1, 4),
                            $urandom_range(1, 8), $urandom_range(1, 8));
               total = splits.kernel_weights();
               count = (total <= 150) ? total * $urandom_range(1, 2) + $urandom_range(0, 3)
                                      : $urandom_range(60, 150);
            end
         endcase
         send_weights(count);
         phase++;
      end

      settle();
      if (splits.mismatches == 0)
         $display("tb_transpose_conv_weight_splitter OK");
      else
         $display("tb_transpose_conv_weight_splitter NOT OK");
      $finish;
   end

endmodule
